// ===== design/snft_pkg.sv =====
// Shared types, constants and the exp table for the spectral noise floor tracker.
// No dependencies; imported by every other file in this folder.
package snft_pkg;

    localparam int MAX_BINS       = 1024;
    localparam int EXP_TABLE_SIZE = 256;
    localparam int BIN_W          = $clog2(MAX_BINS);
    localparam int CNT_W          = BIN_W + 1;
    localparam int EXP_W          = $clog2(EXP_TABLE_SIZE);
    localparam int DIV_Q_W        = 32;

    localparam logic [39:0] PMASK     = 40'hFF_FFFF_FFFF;
    localparam logic [16:0] ONE       = 17'd65536;
    localparam logic [31:0] RATIO_MAX = 32'hFFFF_FFFF;
    localparam logic [10:0] BINS_RESET = 11'd1024;
    localparam logic [15:0] WIN_RESET  = 16'd47;
    localparam logic [15:0] WIN_MIN    = 16'd10;

    localparam logic [16:0] C_SMOOTH = 17'd62259;
    localparam logic [16:0] C_995    = 17'd65208;
    localparam logic [16:0] C_92     = 17'd60293;
    localparam logic [16:0] C_102    = 17'd66847;
    localparam logic [16:0] C_147    = 17'd96338;
    localparam logic [16:0] C_85     = 17'd55706;
    localparam logic [16:0] C_14     = 17'd9175;
    localparam logic [16:0] C_82     = 17'd53740;
    localparam logic [16:0] C_16     = 17'd10486;
    localparam logic [31:0] T_3      = 32'd196608;
    localparam logic [31:0] T_46     = 32'd301466;
    localparam logic [31:0] M_15     = 32'd98304;
    localparam logic [31:0] M_167    = 32'd109445;
    localparam logic [31:0] S_IMCRA  = 32'd192021;
    localparam logic [21:0] W_SPP    = 22'd63527;
    localparam logic [21:0] L_SPP    = 22'd2137968;
    localparam logic [16:0] C_PRES   = 17'd58982;
    localparam logic [16:0] C_STAG   = 17'd64881;
    localparam logic [16:0] C_NOISE  = 17'd52429;

    typedef enum logic [1:0] {
        MODE_STATIC,
        MODE_MCRA,
        MODE_IMCRA,
        MODE_SPP
    } mode_t;

    typedef enum logic [1:0] {
        CFG_MODE,
        CFG_BINS,
        CFG_WINDOW
    } cfg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_BL1,
        ST_BL2,
        ST_SCALE,
        ST_DIVW,
        ST_M_MIN,
        ST_M_Q,
        ST_M_Q2,
        ST_RAMP,
        ST_RAMPD,
        ST_CAP,
        ST_ALPHA,
        ST_BLA,
        ST_NFIN,
        ST_Z_SC,
        ST_Z_FIN,
        ST_P_SNR,
        ST_P_X,
        ST_P_E,
        ST_P_D,
        ST_P_SM,
        ST_P_IN,
        ST_P_OUT,
        ST_P_FIN,
        ST_WB
    } st_t;

    typedef struct packed {
        logic        op;
        logic [39:0] power;
    } item_t;

    typedef struct packed {
        logic [39:0] noise_estimate;
        logic [16:0] speech_presence;
        logic [9:0]  bin_index;
        logic        last_bin;
    } result_t;

    typedef struct packed {
        logic [39:0] nz;
        logic [39:0] sp;
        logic [39:0] cand;
        logic [39:0] loc;
        logic [39:0] prev;
        logic [16:0] spres;
    } row_t;

    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [39:0] den;
    } div_req_t;

    typedef struct packed {
        logic               busy;
        logic [DIV_Q_W-1:0] quo;
    } div_rsp_t;

    typedef struct packed {
        logic        en;
        logic        add;
        logic        rnd;
        logic [39:0] a;
        logic [21:0] b;
    } mac_req_t;

    typedef logic [32:0] exp_tab_t [EXP_TABLE_SIZE];

    // exp(-16k/N) in Q1.32, geometric build from a truncated Taylor ratio
    function automatic exp_tab_t build_exp();
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] acc;
        logic signed [65:0] sum;
        exp_tab_t t;
        int n;
        int k;
        y = (64'd16 << 32) / 64'(EXP_TABLE_SIZE);
        term = 64'd1 << 32;
        sum = 66'sd4294967296;
        acc = 64'd1 << 32;
        for (n = 1; n <= 12; n++)
        begin
            term = ((term * y) >> 32) / 64'(n);
            if (n[0])
                sum = sum - $signed({2'b00, term});
            else
                sum = sum + $signed({2'b00, term});
        end
        if (sum < 0)
            r = 64'd0;
        else if (sum > 66'sd4294967295)
            r = 64'hFFFF_FFFF;
        else
            r = 64'(sum);
        for (k = 0; k < EXP_TABLE_SIZE; k++)
        begin
            t[k] = acc[32:0];
            acc = (acc * r + (64'd1 << 31)) >> 32;
        end
        return t;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp();

    // quotient of (num << 16) / den would not fit in 32 bits
    function automatic logic ratio_over(logic [39:0] num, logic [39:0] den);
        return {16'b0, num} >= {den, 16'b0};
    endfunction

endpackage

// ===== design/snft_div.sv =====
// Restoring divider, one quotient bit per cycle, 32-bit quotient.
// Depends on snft_pkg; requires num[63:32] < den.
module snft_div (
    input  logic               clk,
    input  logic               rst_n,
    input  snft_pkg::div_req_t req,
    output snft_pkg::div_rsp_t rsp
);
    import snft_pkg::*;

    localparam int CW = $clog2(DIV_Q_W);

    logic               busy_reg;
    logic [CW-1:0]      cnt_reg;
    logic [39:0]        rem_reg;
    logic [31:0]        lo_reg;
    logic [DIV_Q_W-1:0] quo_reg;
    logic [39:0]        den_reg;
    logic [40:0]        trial;
    logic               ge;

    assign trial = {rem_reg, lo_reg[31]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            if (cnt_reg == CW'(DIV_Q_W - 1))
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= {8'b0, req.num[63:32]};
            lo_reg  <= req.num[31:0];
            den_reg <= req.den;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 40'(trial - {1'b0, den_reg}) : trial[39:0];
            lo_reg  <= {lo_reg[30:0], 1'b0};
            quo_reg <= {quo_reg[DIV_Q_W-2:0], ge};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.quo  = quo_reg;

endmodule

// ===== design/snft_mac.sv =====
// Shared multiply-accumulate unit: 40 x 22 product, optional add and half-LSB round.
// Depends on snft_pkg.
module snft_mac (
    input  logic               clk,
    input  snft_pkg::mac_req_t req,
    output logic [61:0]        acc
);
    import snft_pkg::*;

    logic [61:0] acc_reg;
    logic [61:0] prod;

    assign prod = 62'(req.a) * 62'(req.b);

    always_ff @(posedge clk)
    begin
        if (req.en)
            acc_reg <= (req.add ? acc_reg : 62'd0) + prod + (req.rnd ? 62'd32768 : 62'd0);
    end

    assign acc = acc_reg;

endmodule

// ===== design/spectral_noise_floor_tracker.sv =====
// Spectral noise floor tracker top level: sequencer, per-bin state memory, output word.
// Depends on snft_pkg, snft_mac and snft_div.
//
//  port group    dir  word      handshake
//  item_*        in   item_t    item_valid / item_ready
//  result_*      out  result_t  result_valid / result_ready
//  cfg_*         in   16 bits   cfg_we, no wait
//
// One word at a time. Restart and initialising-frame words are handled in the idle state
// on acceptance; tracking words step through the sequencer, with each division on the
// shared divider and the products on the shared MAC.
// Reset clears control state only; the bin memory holds nothing until written.
// A word waiting in the output register holds off the next one; write-back waits for it.
module spectral_noise_floor_tracker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  snft_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output snft_pkg::result_t result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);
    import snft_pkg::*;

    st_t              state_reg, state_next;
    st_t              ret_reg, ret_next;
    logic             primed_reg, primed_next;
    logic [BIN_W-1:0] bin_count_reg, bin_count_next;
    logic [15:0]      phase_reg, phase_next;
    logic             result_valid_reg, result_valid_next;
    result_t          result_reg, result_next;

    mode_t            mode_reg;
    logic [10:0]      bins_reg;
    logic [15:0]      win_reg;

    logic [BIN_W-1:0] b_reg, b_next;
    logic             last_reg, last_next;
    logic [39:0]      p_reg, p_next;
    logic [39:0]      praw_reg, praw_next;
    row_t             row_reg, row_next;
    row_t             rd_reg;
    logic [16:0]      bl_w_reg, bl_w_next;
    logic [39:0]      bl_x_reg, bl_x_next;
    logic [39:0]      bl_y_reg, bl_y_next;
    logic             sat_reg, sat_next;
    logic [16:0]      prob_reg, prob_next;
    logic [16:0]      pres_reg, pres_next;
    logic [31:0]      q_reg, q_next;
    logic [39:0]      mn_reg, mn_next;
    logic [39:0]      sec_reg, sec_next;
    logic             strong_reg, strong_next;
    logic [39:0]      cap_reg, cap_next;
    logic [39:0]      t1_reg, t1_next;

    row_t             mem [MAX_BINS];
    logic             mem_we;
    logic             mem_re;
    logic [BIN_W-1:0] mem_waddr;
    row_t             mem_wdata;

    mac_req_t         mac_req;
    logic [61:0]      acc;
    div_req_t         div_req;
    div_rsp_t         div_rsp;

    logic             accept;
    logic [CNT_W-1:0] n_eff;
    logic             is_last;
    logic [15:0]      win_eff;
    logic [16:0]      phase_inc;
    logic [39:0]      p_in;
    row_t             init_row;
    logic [39:0]      bl_res;
    logic [39:0]      sc_res;
    logic [31:0]      div_q;
    logic [39:0]      cand_v, loc_new, prev_new, cand_new, mnmin, mn_v;
    logic             strong_v;
    logic [39:0]      prevf, sec_v;
    logic [31:0]      ramp_lo, ramp_span, ramp_d;
    logic [31:0]      x_v;
    logic [47:0]      kx_v;
    logic [27:0]      k_v;
    logic [32:0]      e_v;
    logic [39:0]      d_v;
    logic [16:0]      pres_v, sm_v, gated_v, alpha_v;
    logic [39:0]      target_v, capf, nfin, scm, zfin, nz_out, snr_den;

    snft_mac u_mac (
        .clk (clk),
        .req (mac_req),
        .acc (acc)
    );

    snft_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign item_ready   = (state_reg == ST_IDLE) && (!result_valid_reg || result_ready);
    assign accept       = item_valid && item_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        if (bins_reg == 11'd0)
            n_eff = CNT_W'(1);
        else if (32'(bins_reg) > 32'(MAX_BINS))
            n_eff = CNT_W'(MAX_BINS);
        else
            n_eff = CNT_W'(bins_reg);
    end

    assign is_last   = (CNT_W'(bin_count_reg) + CNT_W'(1)) >= n_eff;
    assign win_eff   = (win_reg < WIN_MIN) ? WIN_MIN : win_reg;
    assign phase_inc = 17'(phase_reg) + 17'd1;
    assign p_in      = (item.power == 40'd0) ? 40'd1 : item.power;
    assign init_row  = '{nz: p_in, sp: p_in, cand: p_in, loc: p_in, prev: p_in, spres: 17'd0};

    assign bl_res = acc[55:16];
    assign sc_res = (acc[61:56] != 6'd0) ? PMASK : acc[55:16];
    assign div_q  = sat_reg ? RATIO_MAX : div_rsp.quo;

    // window minima
    assign cand_v   = (row_reg.cand < bl_res) ? row_reg.cand : bl_res;
    assign loc_new  = (phase_reg != 16'd0)
                      ? ((row_reg.loc < cand_v) ? row_reg.loc : cand_v) : cand_v;
    assign prev_new = (phase_reg != 16'd0) ? row_reg.prev : row_reg.loc;
    assign cand_new = (phase_reg != 16'd0) ? cand_v : bl_res;
    assign mnmin    = (loc_new < prev_new) ? loc_new : prev_new;
    assign mn_v     = (mnmin == 40'd0) ? 40'd1 : mnmin;

    assign strong_v = div_q > T_46;
    assign prevf    = (row_reg.prev == 40'd0) ? 40'd1 : row_reg.prev;
    assign sec_v    = strong_v ? prevf : mn_reg;

    assign ramp_lo   = (mode_reg == MODE_MCRA) ? M_15 : M_167;
    assign ramp_span = (mode_reg == MODE_MCRA) ? M_15 : S_IMCRA;
    assign ramp_d    = q_reg - ramp_lo;

    // SPP: exp lookup and presence
    assign x_v   = acc[47:16];
    assign kx_v  = 48'(x_v) * 48'(EXP_TABLE_SIZE);
    assign k_v   = kx_v[47:20];
    assign e_v   = (32'(k_v) < 32'(EXP_TABLE_SIZE)) ? EXP_TAB[k_v[EXP_W-1:0]] : 33'd0;
    assign d_v   = 40'h01_0000_0000 + acc[55:16];
    assign pres_v  = (div_q > 32'(ONE)) ? ONE : div_q[16:0];
    assign sm_v    = bl_res[16:0];
    assign gated_v = (sm_v > C_STAG) ? ((pres_reg > C_STAG) ? C_STAG : pres_reg) : pres_reg;
    assign snr_den = (row_reg.nz == 40'd0) ? 40'd1 : row_reg.nz;

    assign alpha_v  = (mode_reg == MODE_IMCRA && strong_reg) ? C_995
                      : (((mode_reg == MODE_MCRA) ? C_85 : C_82) + acc[32:16]);
    assign target_v = (mode_reg == MODE_IMCRA && strong_reg) ? cap_reg : row_reg.sp;
    assign capf     = (cap_reg == 40'd0) ? 40'd1 : cap_reg;
    assign nfin     = (bl_res < capf) ? bl_res : capf;
    assign scm      = (sc_res > mn_reg) ? sc_res : mn_reg;
    assign zfin     = (t1_reg < scm) ? t1_reg : scm;
    assign nz_out   = (row_reg.nz == 40'd0) ? 40'd1 : row_reg.nz;

    always_comb
    begin
        state_next        = state_reg;
        ret_next          = ret_reg;
        primed_next       = primed_reg;
        bin_count_next    = bin_count_reg;
        phase_next        = phase_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        b_next            = b_reg;
        last_next         = last_reg;
        p_next            = p_reg;
        praw_next         = praw_reg;
        row_next          = row_reg;
        bl_w_next         = bl_w_reg;
        bl_x_next         = bl_x_reg;
        bl_y_next         = bl_y_reg;
        sat_next          = sat_reg;
        prob_next         = prob_reg;
        pres_next         = pres_reg;
        q_next            = q_reg;
        mn_next           = mn_reg;
        sec_next          = sec_reg;
        strong_next       = strong_reg;
        cap_next          = cap_reg;
        t1_next           = t1_reg;
        mem_we            = 1'b0;
        mem_re            = 1'b0;
        mem_waddr         = b_reg;
        mem_wdata         = row_reg;
        mac_req           = '0;
        div_req           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.op)
                    begin
                        primed_next    = 1'b0;
                        bin_count_next = '0;
                        phase_next     = 16'd0;
                    end
                    else
                    begin
                        b_next         = bin_count_reg;
                        last_next      = is_last;
                        p_next         = p_in;
                        praw_next      = item.power;
                        bin_count_next = is_last ? '0 : bin_count_reg + BIN_W'(1);
                        if (!primed_reg)
                        begin
                            mem_we            = 1'b1;
                            mem_waddr         = bin_count_reg;
                            mem_wdata         = init_row;
                            result_valid_next = 1'b1;
                            result_next       = '{noise_estimate: p_in, speech_presence: 17'd0,
                                                  bin_index: 10'(bin_count_reg),
                                                  last_bin: is_last};
                            if (is_last)
                            begin
                                primed_next = 1'b1;
                                phase_next  = 16'd1;
                            end
                        end
                        else
                        begin
                            if (bin_count_reg == '0)
                                phase_next = (phase_inc >= 17'(win_eff)) ? 16'd0
                                                                         : phase_inc[15:0];
                            mem_re     = 1'b1;
                            state_next = ST_LOAD;
                        end
                    end
                end
            end

            ST_LOAD:
            begin
                row_next = rd_reg;
                if (mode_reg == MODE_SPP)
                    state_next = ST_P_SNR;
                else
                begin
                    bl_w_next  = C_SMOOTH;
                    bl_x_next  = rd_reg.sp;
                    bl_y_next  = p_reg;
                    ret_next   = ST_M_MIN;
                    state_next = ST_BL1;
                end
            end

            ST_BL1:
            begin
                mac_req    = '{en: 1'b1, add: 1'b0, rnd: 1'b0, a: bl_x_reg, b: 22'(bl_w_reg)};
                state_next = ST_BL2;
            end

            ST_BL2:
            begin
                mac_req    = '{en: 1'b1, add: 1'b1, rnd: 1'b1, a: bl_y_reg,
                               b: 22'(ONE - bl_w_reg)};
                state_next = ret_reg;
            end

            ST_SCALE:
            begin
                mac_req    = '{en: 1'b1, add: 1'b0, rnd: 1'b1, a: bl_x_reg, b: 22'(bl_w_reg)};
                state_next = ret_reg;
            end

            ST_DIVW:
            begin
                if (!div_rsp.busy)
                    state_next = ret_reg;
            end

            ST_M_MIN:
            begin
                row_next.sp   = bl_res;
                row_next.cand = cand_new;
                row_next.loc  = loc_new;
                row_next.prev = prev_new;
                mn_next       = mn_v;
                sec_next      = mn_v;
                div_req       = '{start: 1'b1, num: {8'b0, bl_res, 16'b0}, den: mn_v};
                sat_next      = ratio_over(bl_res, mn_v);
                ret_next      = ST_M_Q;
                state_next    = ST_DIVW;
            end

            ST_M_Q:
            begin
                case (mode_reg)
                    MODE_STATIC:
                    begin
                        prob_next  = (div_q > T_3) ? ONE : 17'd0;
                        bl_w_next  = (div_q > T_3) ? C_995 : C_92;
                        bl_x_next  = row_reg.nz;
                        bl_y_next  = praw_reg;
                        ret_next   = ST_Z_SC;
                        state_next = ST_BL1;
                    end
                    MODE_MCRA:
                    begin
                        q_next     = div_q;
                        state_next = ST_RAMP;
                    end
                    default:
                    begin
                        strong_next = strong_v;
                        sec_next    = sec_v;
                        div_req     = '{start: 1'b1, num: {8'b0, row_reg.sp, 16'b0}, den: sec_v};
                        sat_next    = ratio_over(row_reg.sp, sec_v);
                        ret_next    = ST_M_Q2;
                        state_next  = ST_DIVW;
                    end
                endcase
            end

            ST_M_Q2:
            begin
                q_next     = div_q;
                state_next = ST_RAMP;
            end

            ST_RAMP:
            begin
                if (q_reg <= ramp_lo)
                begin
                    prob_next  = 17'd0;
                    state_next = ST_CAP;
                end
                else if (ramp_d >= ramp_span)
                begin
                    prob_next  = ONE;
                    state_next = ST_CAP;
                end
                else
                begin
                    div_req    = '{start: 1'b1, num: {16'b0, ramp_d, 16'b0},
                                   den: 40'(ramp_span)};
                    sat_next   = 1'b0;
                    ret_next   = ST_RAMPD;
                    state_next = ST_DIVW;
                end
            end

            ST_RAMPD:
            begin
                prob_next  = div_q[16:0];
                state_next = ST_CAP;
            end

            ST_CAP:
            begin
                bl_x_next  = sec_reg;
                bl_w_next  = C_147;
                ret_next   = ST_ALPHA;
                state_next = ST_SCALE;
            end

            ST_ALPHA:
            begin
                cap_next   = sc_res;
                mac_req    = '{en: 1'b1, add: 1'b0, rnd: 1'b1, a: 40'(prob_reg),
                               b: 22'((mode_reg == MODE_MCRA) ? C_14 : C_16)};
                state_next = ST_BLA;
            end

            ST_BLA:
            begin
                bl_w_next  = alpha_v;
                bl_x_next  = row_reg.nz;
                bl_y_next  = target_v;
                ret_next   = ST_NFIN;
                state_next = ST_BL1;
            end

            ST_NFIN:
            begin
                row_next.nz = nfin;
                state_next  = ST_WB;
            end

            ST_Z_SC:
            begin
                t1_next    = bl_res;
                bl_x_next  = row_reg.nz;
                bl_w_next  = C_102;
                ret_next   = ST_Z_FIN;
                state_next = ST_SCALE;
            end

            ST_Z_FIN:
            begin
                row_next.nz = zfin;
                state_next  = ST_WB;
            end

            ST_P_SNR:
            begin
                div_req    = '{start: 1'b1, num: {8'b0, p_reg, 16'b0}, den: snr_den};
                sat_next   = ratio_over(p_reg, snr_den);
                ret_next   = ST_P_X;
                state_next = ST_DIVW;
            end

            ST_P_X:
            begin
                mac_req    = '{en: 1'b1, add: 1'b0, rnd: 1'b1, a: 40'(div_q), b: W_SPP};
                state_next = ST_P_E;
            end

            ST_P_E:
            begin
                mac_req    = '{en: 1'b1, add: 1'b0, rnd: 1'b0, a: 40'(e_v), b: L_SPP};
                state_next = ST_P_D;
            end

            ST_P_D:
            begin
                div_req    = '{start: 1'b1, num: 64'h0001_0000_0000_0000 + 64'(d_v >> 1),
                               den: d_v};
                sat_next   = 1'b0;
                ret_next   = ST_P_SM;
                state_next = ST_DIVW;
            end

            ST_P_SM:
            begin
                pres_next  = pres_v;
                bl_w_next  = C_PRES;
                bl_x_next  = 40'(row_reg.spres);
                bl_y_next  = 40'(pres_v);
                ret_next   = ST_P_IN;
                state_next = ST_BL1;
            end

            ST_P_IN:
            begin
                row_next.spres = sm_v;
                prob_next      = gated_v;
                bl_w_next      = gated_v;
                bl_x_next      = row_reg.nz;
                bl_y_next      = p_reg;
                ret_next       = ST_P_OUT;
                state_next     = ST_BL1;
            end

            ST_P_OUT:
            begin
                bl_w_next  = C_NOISE;
                bl_x_next  = row_reg.nz;
                bl_y_next  = bl_res;
                ret_next   = ST_P_FIN;
                state_next = ST_BL1;
            end

            ST_P_FIN:
            begin
                row_next.nz = bl_res;
                state_next  = ST_WB;
            end

            ST_WB:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    mem_we            = 1'b1;
                    mem_waddr         = b_reg;
                    mem_wdata         = row_reg;
                    mem_wdata.nz      = nz_out;
                    result_valid_next = 1'b1;
                    result_next       = '{noise_estimate: nz_out, speech_presence: prob_reg,
                                          bin_index: 10'(b_reg), last_bin: last_reg};
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            primed_reg       <= 1'b0;
            bin_count_reg    <= '0;
            phase_reg        <= 16'd0;
            result_valid_reg <= 1'b0;
            mode_reg         <= MODE_STATIC;
            bins_reg         <= BINS_RESET;
            win_reg          <= WIN_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            primed_reg       <= primed_next;
            bin_count_reg    <= bin_count_next;
            phase_reg        <= phase_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MODE:   mode_reg <= mode_t'(cfg_data[1:0]);
                    CFG_BINS:   bins_reg <= cfg_data[10:0];
                    CFG_WINDOW: win_reg  <= cfg_data;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ret_reg    <= ret_next;
        result_reg <= result_next;
        b_reg      <= b_next;
        last_reg   <= last_next;
        p_reg      <= p_next;
        praw_reg   <= praw_next;
        row_reg    <= row_next;
        bl_w_reg   <= bl_w_next;
        bl_x_reg   <= bl_x_next;
        bl_y_reg   <= bl_y_next;
        sat_reg    <= sat_next;
        prob_reg   <= prob_next;
        pres_reg   <= pres_next;
        q_reg      <= q_next;
        mn_reg     <= mn_next;
        sec_reg    <= sec_next;
        strong_reg <= strong_next;
        cap_reg    <= cap_next;
        t1_reg     <= t1_next;
    end

    // per-bin state memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_reg <= mem[bin_count_reg];
    end

endmodule

// ===== dv/spectral_noise_floor_tracker_tb.sv =====
// Self-checking testbench for spectral_noise_floor_tracker: directed table, then random
// frames in all four tracking modes, checked word by word against an in-bench predictor.
// Depends on snft_pkg and the design under design/.
module spectral_noise_floor_tracker_tb;
    import snft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned u64;

    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_RESTART = 1'b1;
    localparam int   IDLE_LIMIT = 20000;
    localparam int   SETTLE     = 200;
    localparam int   HOLD_LEN   = 3000;
    localparam int   BIG_WORDS  = 150;
    localparam u64   PWR_MAX    = 64'hFF_FFFF_FFFF;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    item_t   item;
    logic    result_valid;
    logic    result_ready;
    result_t result;
    logic    cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    spectral_noise_floor_tracker DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // tracker model state
    u64 nf_mem   [MAX_BINS];
    u64 sp_mem   [MAX_BINS];
    u64 cand_mem [MAX_BINS];
    u64 loc_mem  [MAX_BINS];
    u64 prev_mem [MAX_BINS];
    u64 spres_mem[MAX_BINS];
    u64 exp_lut  [EXP_TABLE_SIZE];
    u64 m_mode = u64'(MODE_STATIC);
    u64 m_bins = u64'(BINS_RESET);
    u64 m_win  = u64'(WIN_RESET);
    u64 frame_ph;
    u64 bin_cnt;
    bit is_primed;

    result_t expected_q[$];
    int  mismatches = 0;
    int  n_results = 0;
    int  n_words = 0;
    int  idle_sel;
    int  idle_cnt = 0;
    bit  hold_start;
    bit  hold_done;
    int  hold_left;

    // typed expectation riding along with the offered word
    logic    typed_valid;
    result_t typed_res;

    function automatic u64 umin(u64 a, u64 b);
        return a < b ? a : b;
    endfunction

    function automatic u64 umax(u64 a, u64 b);
        return a > b ? a : b;
    endfunction

    function automatic u64 mix(u64 a, u64 x, u64 y);
        return (a * x + (u64'(ONE) - a) * y + 64'd32768) >> 16;
    endfunction

    function automatic u64 gain(u64 x, u64 k);
        return umin((x * k + 64'd32768) >> 16, PWR_MAX);
    endfunction

    function automatic u64 quot(u64 num, u64 den);
        if (den == 0)
            den = 1;
        return umin((num << 16) / den, 64'hFFFF_FFFF);
    endfunction

    function automatic u64 slope(u64 q, u64 lo, u64 span);
        if (q <= lo)
            return 0;
        if (q - lo >= span)
            return u64'(ONE);
        return ((q - lo) << 16) / span;
    endfunction

    function automatic void build_exp_lut();
        u64 y;
        u64 term;
        u64 acc;
        longint sum;
        y = (64'd16 << 32) / u64'(EXP_TABLE_SIZE);
        term = 64'd1 << 32;
        sum = longint'(64'd1 << 32);
        acc = 64'd1 << 32;
        for (int n = 1; n <= 12; n++)
        begin
            term = ((term * y) >> 32) / u64'(n);
            if (n % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        if (sum > longint'(64'hFFFF_FFFF))
            sum = longint'(64'hFFFF_FFFF);
        for (int k = 0; k < EXP_TABLE_SIZE; k++)
        begin
            exp_lut[k] = acc;
            acc = (acc * u64'(sum) + (64'd1 << 31)) >> 32;
        end
    endfunction

    function automatic u64 presence_update(int b, u64 p);
        u64 nz;
        u64 snr;
        u64 x;
        u64 k;
        u64 e;
        u64 d;
        u64 pres;
        u64 sm;
        u64 gated;
        nz = nf_mem[b];
        snr = quot(p, umax(nz, 1));
        x = (snr * u64'(W_SPP) + 64'd32768) >> 16;
        k = (x * u64'(EXP_TABLE_SIZE)) >> 20;
        e = k < u64'(EXP_TABLE_SIZE) ? exp_lut[k] : 0;
        d = (64'd1 << 32) + ((u64'(L_SPP) * e) >> 16);
        pres = umin(((64'd1 << 48) + d / 2) / d, u64'(ONE));
        sm = mix(u64'(C_PRES), spres_mem[b], pres);
        spres_mem[b] = sm;
        gated = sm > u64'(C_STAG) ? umin(pres, u64'(C_STAG)) : pres;
        nf_mem[b] = umax(mix(u64'(C_NOISE), nz, mix(gated, nz, p)), 1);
        return gated;
    endfunction

    function automatic u64 minimum_update(int b, u64 p, u64 p_raw);
        u64 sp;
        u64 cand;
        u64 nz;
        u64 mn;
        u64 q;
        u64 prob;
        u64 alpha;
        u64 cap;
        u64 sec;
        u64 target;
        bit is_strong;
        sp = mix(u64'(C_SMOOTH), sp_mem[b], p);
        cand = umin(cand_mem[b], sp);
        nz = nf_mem[b];
        sp_mem[b] = sp;
        if (frame_ph != 0)
        begin
            cand_mem[b] = cand;
            loc_mem[b] = umin(loc_mem[b], cand);
        end
        else
        begin
            prev_mem[b] = loc_mem[b];
            loc_mem[b] = cand;
            cand_mem[b] = sp;
        end
        mn = umax(umin(loc_mem[b], prev_mem[b]), 1);
        q = quot(sp, mn);
        if (m_mode == u64'(MODE_STATIC))
        begin
            prob = q > u64'(T_3) ? u64'(ONE) : 0;
            alpha = prob != 0 ? u64'(C_995) : u64'(C_92);
            nz = umin(mix(alpha, nz, p_raw), umax(gain(nz, u64'(C_102)), mn));
        end
        else if (m_mode == u64'(MODE_MCRA))
        begin
            prob = slope(q, u64'(M_15), u64'(M_15));
            alpha = u64'(C_85) + ((u64'(C_14) * prob + 64'd32768) >> 16);
            nz = umin(mix(alpha, nz, sp), umax(gain(mn, u64'(C_147)), 1));
        end
        else
        begin
            is_strong = q > u64'(T_46);
            sec = is_strong ? umax(prev_mem[b], 1) : mn;
            prob = slope(quot(sp, sec), u64'(M_167), u64'(S_IMCRA));
            alpha = is_strong ? u64'(C_995)
                              : u64'(C_82) + ((u64'(C_16) * prob + 64'd32768) >> 16);
            cap = gain(sec, u64'(C_147));
            target = is_strong ? cap : sp;
            nz = umin(mix(alpha, nz, target), umax(cap, 1));
        end
        nf_mem[b] = umax(nz, 1);
        return prob;
    endfunction

    function automatic bit track_word(input item_t w, output result_t r);
        u64 n;
        u64 win;
        int b;
        u64 p_raw;
        u64 p;
        u64 pres;
        bit last;
        r = '0;
        if (w.op == OP_RESTART)
        begin
            is_primed = 0;
            bin_cnt = 0;
            frame_ph = 0;
            return 0;
        end
        n = m_bins < 1 ? 1 : (m_bins > MAX_BINS ? MAX_BINS : m_bins);
        win = m_win < 10 ? 10 : m_win;
        b = bin_cnt < MAX_BINS ? int'(bin_cnt) : 0;
        p_raw = u64'(w.power);
        p = p_raw != 0 ? p_raw : 1;
        last = u64'(b) + 1 >= n;
        if (!is_primed)
        begin
            nf_mem[b] = p;
            sp_mem[b] = p;
            loc_mem[b] = p;
            prev_mem[b] = p;
            cand_mem[b] = p;
            spres_mem[b] = 0;
            pres = 0;
        end
        else
        begin
            if (b == 0)
                frame_ph = (frame_ph + 1 >= win) ? 0 : frame_ph + 1;
            pres = (m_mode == u64'(MODE_SPP)) ? presence_update(b, p)
                                              : minimum_update(b, p, p_raw);
        end
        r.noise_estimate = nf_mem[b][39:0];
        r.speech_presence = pres[16:0];
        r.bin_index = b[9:0];
        r.last_bin = last;
        if (last)
        begin
            bin_cnt = 0;
            if (!is_primed)
            begin
                is_primed = 1;
                frame_ph = 1;
            end
        end
        else
            bin_cnt = u64'(b) + 1;
        return 1;
    endfunction

    // predictor, config shadow and word checking
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        if (rst_n && result_valid && result_ready)
        begin
            n_results++;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", result);
            end
            else
            begin
                want = expected_q.pop_front();
                got = result;
                if (got.noise_estimate !== want.noise_estimate
                    || got.speech_presence !== want.speech_presence
                    || got.bin_index !== want.bin_index
                    || got.last_bin !== want.last_bin)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp nz=%h pr=%0d bin=%0d last=%b, %s",
                                 want.noise_estimate, want.speech_presence, want.bin_index,
                                 want.last_bin,
                                 $sformatf("got nz=%h pr=%0d bin=%0d last=%b",
                                           got.noise_estimate, got.speech_presence,
                                           got.bin_index, got.last_bin));
                end
            end
        end
        if (rst_n && item_valid && item_ready)
        begin
            n_words++;
            if (track_word(item, want))
            begin
                if (typed_valid)
                    expected_q.push_back(typed_res);
                else
                    expected_q.push_back(want);
            end
        end
        if (rst_n && cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_MODE:   m_mode = u64'(cfg_data[1:0]);
                CFG_BINS:   m_bins = u64'(cfg_data[10:0]);
                CFG_WINDOW: m_win = u64'(cfg_data);
                default:    ;
            endcase
        end
    end

    function automatic int send_idle_pct();
        return idle_sel == 0 ? 21 : (idle_sel == 1 ? 65 : 0);
    endfunction

    function automatic int recv_idle_pct();
        return idle_sel == 0 ? 65 : (idle_sel == 1 ? 21 : 0);
    endfunction

    // receiver with random stalls and one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_start && !hold_done)
        begin
            hold_done <= 1'b1;
            hold_left <= HOLD_LEN;
            result_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else
            result_ready <= ($urandom_range(99) >= recv_idle_pct());
    end

    // watchdog on handshake activity
    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic put_word(input logic op, input logic [39:0] pwr,
                            input bit typed, input result_t tr);
        if ($urandom_range(99) < send_idle_pct())
        begin
            item_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct());
        end
        item_valid <= 1'b1;
        item <= '{op: op, power: pwr};
        typed_valid <= typed;
        typed_res <= tr;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        typed_valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic int eff_bins(int v);
        return v < 1 ? 1 : (v > MAX_BINS ? MAX_BINS : v);
    endfunction

    function automatic logic [39:0] pick_power(u64 base);
        int r;
        u64 v;
        r = $urandom_range(99);
        if (r < 3)
            v = 0;
        else if (r < 8)
            v = {$urandom, $urandom};
        else if (r < 20)
            v = base * 64 * u64'($urandom_range(1, 4));
        else
            v = base + base * u64'($urandom_range(0, 300)) / 100;
        return v > PWR_MAX ? PWR_MAX[39:0] : v[39:0];
    endfunction

    typedef struct {
        logic        op;
        logic [39:0] power;
        bit          typed;
        logic [39:0] nz;
    } dir_row_t;

    dir_row_t dir_rows[21] = '{
        '{OP_RESTART, 40'd0,               0, 40'd0},
        '{OP_SAMPLE,  40'd0,               1, 40'd1},
        '{OP_SAMPLE,  40'hFF_FFFF_FFFF,    1, 40'hFF_FFFF_FFFF},
        '{OP_SAMPLE,  40'd1,               1, 40'd1},
        '{OP_SAMPLE,  40'h00_0100_0000,    1, 40'h00_0100_0000},
        '{OP_SAMPLE,  40'h00_0100_0000,    0, 40'd0},
        '{OP_SAMPLE,  40'h00_0000_0000,    0, 40'd0},
        '{OP_SAMPLE,  40'hFF_FFFF_FFFF,    0, 40'd0},
        '{OP_SAMPLE,  40'h00_4000_0000,    0, 40'd0},
        '{OP_SAMPLE,  40'hFF_FFFF_FFFF,    0, 40'd0},
        '{OP_SAMPLE,  40'h00_0000_0001,    0, 40'd0},
        '{OP_SAMPLE,  40'h00_0000_0000,    0, 40'd0},
        '{OP_SAMPLE,  40'h55_5555_5555,    0, 40'd0},
        '{OP_SAMPLE,  40'hAA_AAAA_AAAA,    0, 40'd0},
        '{OP_SAMPLE,  40'h00_0000_0000,    0, 40'd0},
        '{OP_SAMPLE,  40'h00_0010_0000,    0, 40'd0},
        '{OP_RESTART, 40'hFF_FFFF_FFFF,    0, 40'd0},
        '{OP_SAMPLE,  40'h00_0200_0000,    1, 40'h00_0200_0000},
        '{OP_SAMPLE,  40'h00_0000_0000,    1, 40'd1},
        '{OP_SAMPLE,  40'h12_3456_789A,    1, 40'h12_3456_789A},
        '{OP_SAMPLE,  40'h00_0000_0002,    1, 40'd2}
    };

    int bins_pick[10] = '{0, 1, 3, 4, 4, 7, 5, 16, 2, 1100};
    int win_pick[6]   = '{0, 10, 11, 12, 47, 65535};

    initial
    begin
        int      bin_pos;
        int      cur_n;
        int      rnd_words;
        int      phases;
        int      md;
        int      bn;
        int      wn;
        int      cnt;
        u64      base;
        result_t tr;
        rst_n = 1'b0;
        item_valid = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_MODE;
        cfg_data = '0;
        typed_valid = 1'b0;
        typed_res = '0;
        hold_start = 1'b0;
        idle_sel = 0;
        build_exp_lut();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 4 bins, static mode, shortest window
        write_reg(CFG_MODE, 16'(MODE_STATIC));
        write_reg(CFG_BINS, 16'd4);
        write_reg(CFG_WINDOW, 16'd10);
        bin_pos = 0;
        foreach (dir_rows[i])
        begin
            tr = '0;
            if (dir_rows[i].op == OP_RESTART)
                bin_pos = 0;
            else
            begin
                tr.noise_estimate = dir_rows[i].nz;
                tr.bin_index = 10'(bin_pos);
                tr.last_bin = (bin_pos == 3);
                bin_pos = (bin_pos + 1) % 4;
            end
            put_word(dir_rows[i].op, dir_rows[i].power, dir_rows[i].typed, tr);
        end
        cur_n = 4;

        // random phases; a large frame stays in its initialising pass and forces a
        // restart before the next phase
        rnd_words = 0;
        phases = 0;
        while (rnd_words < 750)
        begin
            wait_idle();
            idle_sel = rnd_words < 250 ? 0 : (rnd_words < 500 ? 1 : 2);
            md = phases < 4 ? (phases + 1) % 4 : $urandom_range(3);
            bn = phases == 5 ? 2047 : bins_pick[$urandom_range(9)];
            if (bn == 1100 && phases != 7)
                bn = 8;
            wn = win_pick[$urandom_range(5)];
            write_reg(CFG_MODE, 16'(md));
            write_reg(CFG_BINS, 16'(bn));
            write_reg(CFG_WINDOW, 16'(wn));
            if (eff_bins(bn) > cur_n || eff_bins(bn) >= 512 || $urandom_range(3) == 0)
            begin
                put_word(OP_RESTART, {$urandom, $urandom}, 0, '0);
                cur_n = eff_bins(bn);
            end
            if (phases == 1)
                hold_start = 1'b1;
            base = 64'd1 << $urandom_range(4, 34);
            cnt = eff_bins(bn) >= 512 ? BIG_WORDS : $urandom_range(40, 90);
            repeat (cnt)
            begin
                if ($urandom_range(99) < 2)
                begin
                    put_word(OP_RESTART, {$urandom, $urandom}, 0, '0);
                    cur_n = eff_bins(bn);
                end
                else
                    put_word(OP_SAMPLE, pick_power(base), 0, '0);
                rnd_words++;
            end
            if (eff_bins(bn) >= 512)
                cur_n = 0;
            phases++;
        end
        wait_idle();

        $display("covered %0d words and %0d results over %0d random phases, all four modes",
                 n_words, n_results, phases);
        $display("bin counts 1 to 1024 incl. out-of-range settings, windows 10 to 65535");
        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb: success");
        else
        begin
            $display("%0d mismatches, %0d results outstanding", mismatches, expected_q.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/snft_pkg.sv
design/snft_div.sv
design/snft_mac.sv
design/spectral_noise_floor_tracker.sv
dv/spectral_noise_floor_tracker_tb.sv
